[sv/rc4_pkg.sv]
package rc4_pkg;

    // Sizes of the permutation and the key store
    localparam int BYTE_W        = 8;
    localparam int TABLE_SIZE    = 256;
    localparam int MAX_KEY_BYTES = 256;
    localparam int CNT_W         = $clog2(TABLE_SIZE) + 1;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CNT_W-1:0]  t_count;

    // Item opcodes
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

endpackage

[sv/rc4_if.sv]
// Input channel: one key or data byte per item
interface rc4_in_if;
    logic            valid;
    logic            ready;
    logic            opcode;
    rc4_pkg::t_byte  byte_in;
    logic            key_last;

    modport source (output valid, output opcode, output byte_in, output key_last,
                    input ready);
    modport sink   (input valid, input opcode, input byte_in, input key_last,
                    output ready);
endinterface

// Output channel: one result byte per data item
interface rc4_out_if;
    logic            valid;
    logic            ready;
    rc4_pkg::t_byte  byte_out;
    logic            not_keyed;

    modport source (output valid, output byte_out, output not_keyed, input ready);
    modport sink   (input valid, input byte_out, input not_keyed, output ready);
endinterface

[sv/rc4_stream_cipher.sv]
// RC4 engine. Key bytes (opcode 0) are taken one per cycle while no result waits
// in the output register, and stored, up to 256; further bytes are dropped. The key
// byte flagged key_last starts the key schedule: the identity permutation is loaded,
// then each entry is swapped in turn, and no item is taken until it ends. A data
// byte (opcode 1) is processed in steps set by the single read port of the
// permutation RAM (read S[i], read S[j], two write-backs, read S[S[i]+S[j]]).
// One item is in flight at a time; a new item is taken once the previous result
// has left the output register. Data before any completed schedule returns 0
// with not_keyed set in the cycle after acceptance. A data byte during a partial
// key load still uses the previous permutation.
module rc4_stream_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rc4_in_if.sink      i_in,
    rc4_out_if.source   o_out
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_KS_RD = 4'd2;
    localparam logic [3:0] ST_KS_J  = 4'd3;
    localparam logic [3:0] ST_KS_SJ = 4'd4;
    localparam logic [3:0] ST_KS_WJ = 4'd5;
    localparam logic [3:0] ST_D_J   = 4'd6;
    localparam logic [3:0] ST_D_SJ  = 4'd7;
    localparam logic [3:0] ST_D_WJ  = 4'd8;
    localparam logic [3:0] ST_D_RD  = 4'd9;
    localparam logic [3:0] ST_D_OUT = 4'd10;

    localparam int AW = $clog2(rc4_pkg::TABLE_SIZE);

    logic [3:0]      r_state, n_state;
    rc4_pkg::t_byte  r_i, n_i, r_j, n_j, r_n, n_n, r_k, n_k;
    rc4_pkg::t_byte  r_si, n_si, r_sj, n_sj, r_data, n_data;
    rc4_pkg::t_count r_len, n_len, r_key_count, n_key_count;
    logic            r_keyed, n_keyed;
    logic            r_out_valid, n_out_valid, r_out_nk, n_out_nk;
    rc4_pkg::t_byte  r_out_byte, n_out_byte;

    // RAM ports
    logic            perm_we;
    logic [AW-1:0]   perm_waddr, perm_raddr;
    rc4_pkg::t_byte  perm_wdata, perm_rdata;
    logic            key_we;
    logic [AW-1:0]   key_raddr;
    rc4_pkg::t_byte  key_rdata;

    // Shared 8-bit adder
    rc4_pkg::t_byte  add_a, add_b, add_c, add_sum;
    rc4_pkg::t_byte  kb;
    rc4_pkg::t_count cnt_inc, k_inc;
    logic            in_fire, key_room;

    rc4_ram #(.DEPTH(rc4_pkg::TABLE_SIZE), .WIDTH(rc4_pkg::BYTE_W)) u_perm (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (perm_waddr),
        .i_wdata (perm_wdata),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rdata)
    );

    rc4_ram #(.DEPTH(rc4_pkg::TABLE_SIZE), .WIDTH(rc4_pkg::BYTE_W)) u_key (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_key_count[AW-1:0]),
        .i_wdata (i_in.byte_in),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    assign i_in.ready      = (r_state == ST_IDLE) && !r_out_valid;
    assign in_fire         = i_in.valid && i_in.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.byte_out  = r_out_byte;
    assign o_out.not_keyed = r_out_nk;

    assign key_room  = r_key_count < rc4_pkg::t_count'(rc4_pkg::MAX_KEY_BYTES);
    assign cnt_inc   = r_key_count + rc4_pkg::t_count'(1);
    assign k_inc     = {1'b0, r_k} + rc4_pkg::t_count'(1);
    assign kb        = (r_len == '0) ? '0 : key_rdata;
    assign key_raddr = r_k;

    // Adder operand selection
    always_comb begin
        add_a = r_n;
        add_b = rc4_pkg::t_byte'(1);
        add_c = '0;
        case (r_state)
            ST_IDLE: begin
                add_a = r_i;
            end
            ST_D_J: begin
                add_a = r_j;
                add_b = perm_rdata;
            end
            ST_KS_J: begin
                add_a = r_j;
                add_b = perm_rdata;
                add_c = kb;
            end
            ST_D_RD: begin
                add_a = r_si;
                add_b = r_sj;
            end
            default: begin
                add_a = r_n;
            end
        endcase
    end

    assign add_sum = add_a + add_b + add_c;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_k         = r_k;
        n_si        = r_si;
        n_sj        = r_sj;
        n_data      = r_data;
        n_len       = r_len;
        n_key_count = r_key_count;
        n_keyed     = r_keyed;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_nk    = r_out_nk;
        n_out_byte  = r_out_byte;
        perm_we     = 1'b0;
        perm_waddr  = r_n;
        perm_wdata  = r_n;
        perm_raddr  = r_n;
        key_we      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_in.opcode == rc4_pkg::OP_KEY) begin
                    key_we = key_room;
                    if (i_in.key_last) begin
                        n_len       = key_room ? cnt_inc : r_key_count;
                        n_key_count = '0;
                        n_n         = '0;
                        n_state     = ST_FILL;
                    end else if (key_room) begin
                        n_key_count = cnt_inc;
                    end
                end else if (in_fire && !r_keyed) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = '0;
                    n_out_nk    = 1'b1;
                end else if (in_fire) begin
                    perm_raddr = add_sum;
                    n_i        = add_sum;
                    n_data     = i_in.byte_in;
                    n_state    = ST_D_J;
                end
            end
            // Identity load
            ST_FILL: begin
                perm_we    = 1'b1;
                n_n        = add_sum;
                if (r_n == '1) begin
                    n_j     = '0;
                    n_k     = '0;
                    n_state = ST_KS_RD;
                end
            end
            ST_KS_RD: begin
                n_state = ST_KS_J;
            end
            ST_KS_J: begin
                n_si       = perm_rdata;
                n_j        = add_sum;
                perm_raddr = add_sum;
                n_state    = ST_KS_SJ;
            end
            ST_KS_SJ: begin
                perm_we    = 1'b1;
                perm_wdata = perm_rdata;
                n_state    = ST_KS_WJ;
            end
            ST_KS_WJ: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
                n_n        = add_sum;
                n_k        = (k_inc >= r_len) ? '0 : k_inc[AW-1:0];
                n_state    = ST_KS_RD;
                if (r_n == '1) begin
                    n_keyed = 1'b1;
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_IDLE;
                end
            end
            // Keystream step
            ST_D_J: begin
                n_si       = perm_rdata;
                n_j        = add_sum;
                perm_raddr = add_sum;
                n_state    = ST_D_SJ;
            end
            ST_D_SJ: begin
                n_sj       = perm_rdata;
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = perm_rdata;
                n_state    = ST_D_WJ;
            end
            ST_D_WJ: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
                n_state    = ST_D_RD;
            end
            ST_D_RD: begin
                perm_raddr = add_sum;
                n_state    = ST_D_OUT;
            end
            ST_D_OUT: begin
                n_out_valid = 1'b1;
                n_out_byte  = r_data ^ perm_rdata;
                n_out_nk    = 1'b0;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_key_count <= '0;
            r_keyed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_j         <= n_j;
            r_key_count <= n_key_count;
            r_keyed     <= n_keyed;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_k        <= n_k;
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_data     <= n_data;
        r_len      <= n_len;
        r_out_nk   <= n_out_nk;
        r_out_byte <= n_out_byte;
    end

    // Checks
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_IDLE || $past(r_state) == ST_D_OUT)
        else $error("result raised outside idle or output step");

    a_nk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_nk |-> r_out_byte == '0)
        else $error("unkeyed result carries nonzero byte");

    a_sched_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_KS_WJ && r_n == '1 |=> r_keyed && r_i == '0 && r_j == '0
            && r_state == ST_IDLE)
        else $error("schedule end left bad state");

    a_key_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= rc4_pkg::t_count'(rc4_pkg::MAX_KEY_BYTES))
        else $error("key count overflow");

endmodule

[sv/rc4_ram.sv]
// Simple dual-port RAM: one write port, one registered read port
module rc4_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[dv/tb_top.sv]
// One expected result item
typedef struct packed {
    rc4_pkg::t_byte byte_out;
    logic           not_keyed;
} t_rc4_result;

// Keystream predictor plus the queue of results still to come
class rc4_scoreboard;
    rc4_pkg::t_byte  perm [rc4_pkg::TABLE_SIZE];
    rc4_pkg::t_byte  key_bytes [rc4_pkg::TABLE_SIZE];
    rc4_pkg::t_count key_len;
    rc4_pkg::t_byte  idx_i;
    rc4_pkg::t_byte  idx_j;
    bit              keyed;
    t_rc4_result     expected_q [$];
    int              mismatches;
    int              results_seen;
    int              unkeyed_results;
    int              schedules;
    int              key_bytes_taken;
    int              key_bytes_dropped;

    function new();
        key_len           = '0;
        idx_i             = '0;
        idx_j             = '0;
        keyed             = 1'b0;
        mismatches        = 0;
        results_seen      = 0;
        unkeyed_results   = 0;
        schedules         = 0;
        key_bytes_taken   = 0;
        key_bytes_dropped = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    task report(input string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("MISMATCH: %s", msg);
    endtask

    // Update the predicted state for one accepted input item
    function void note_input(input logic op, input rc4_pkg::t_byte b, input logic last);
        rc4_pkg::t_byte jj;
        rc4_pkg::t_byte tmp;
        rc4_pkg::t_byte kb;
        t_rc4_result    r;
        if (op == rc4_pkg::OP_KEY) begin
            // Bytes past a full store are dropped
            if (key_len < rc4_pkg::MAX_KEY_BYTES) begin
                key_bytes[key_len[7:0]] = b;
                key_len++;
                key_bytes_taken++;
            end else begin
                key_bytes_dropped++;
            end
            if (last) begin
                // Key schedule: identity, then scramble with the key repeated
                for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++)
                    perm[n] = rc4_pkg::t_byte'(n);
                jj = '0;
                for (int n = 0; n < rc4_pkg::TABLE_SIZE; n++) begin
                    kb       = (key_len != 0) ? key_bytes[n % key_len] : '0;
                    jj       = jj + perm[n] + kb;
                    tmp      = perm[n];
                    perm[n]  = perm[jj];
                    perm[jj] = tmp;
                end
                idx_i   = '0;
                idx_j   = '0;
                key_len = '0;
                keyed   = 1'b1;
                schedules++;
            end
            return;
        end
        if (!keyed) begin
            // Data ahead of any key: zero, flagged, state untouched
            r.byte_out  = '0;
            r.not_keyed = 1'b1;
            unkeyed_results++;
        end else begin
            idx_i       = idx_i + 8'd1;
            idx_j       = idx_j + perm[idx_i];
            tmp         = perm[idx_i];
            perm[idx_i] = perm[idx_j];
            perm[idx_j] = tmp;
            tmp         = perm[idx_i] + perm[idx_j];
            r.byte_out  = b ^ perm[tmp];
            r.not_keyed = 1'b0;
        end
        expected_q.push_back(r);
    endfunction

    // Compare one accepted result item with the oldest prediction
    task check_result(input rc4_pkg::t_byte got_byte, input logic got_nk);
        t_rc4_result want;
        results_seen++;
        if (expected_q.size() == 0) begin
            report($sformatf("result with none pending: byte_out=%02h not_keyed=%0b",
                             got_byte, got_nk));
            return;
        end
        want = expected_q.pop_front();
        if (got_byte !== want.byte_out)
            report($sformatf("result %0d byte_out=%02h, predicted %02h",
                             results_seen, got_byte, want.byte_out));
        if (got_nk !== want.not_keyed)
            report($sformatf("result %0d not_keyed=%0b, predicted %0b",
                             results_seen, got_nk, want.not_keyed));
    endtask

    task flush_leftovers();
        t_rc4_result want;
        while (expected_q.size() != 0) begin
            want = expected_q.pop_front();
            report($sformatf("result never came: byte_out=%02h not_keyed=%0b",
                             want.byte_out, want.not_keyed));
        end
    endtask
endclass

module tb_top;

    localparam int N_ITEMS      = 1350;
    localparam int PHASE_ITEMS  = 150;
    localparam int QUIET_LIMIT  = 6000;
    localparam int TAIL_CYCLES  = 1500;

    logic i_clk;
    logic i_rst_n;

    rc4_in_if  in_if ();
    rc4_out_if out_if ();

    rc4_stream_cipher i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    rc4_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle / stall mix per phase
    task automatic set_phase(input int p);
        case (p % 4)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 79;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 79;
            end
            default: begin
                send_idle_pct  = 23;
                recv_stall_pct = 23;
            end
        endcase
    endtask

    // Drive one input item and wait until it is taken
    task automatic send_item(input logic op, input rc4_pkg::t_byte b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.opcode   <= op;
        in_if.byte_in  <= b;
        in_if.key_last <= last;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        sb.note_input(op, b, last);
        items_sent++;
    endtask

    // Random data bytes; key_last is junk on data items
    task automatic send_data(input int count);
        for (int k = 0; k < count; k++)
            send_item(rc4_pkg::OP_DATA, rc4_pkg::t_byte'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
    endtask

    // Random key of len bytes, with data slipped into the partial load at times
    task automatic send_key(input int len, input int data_pct);
        for (int k = 0; k < len; k++) begin
            send_item(rc4_pkg::OP_KEY, rc4_pkg::t_byte'($urandom_range(0, 255)),
                      k == len - 1);
            if (k != len - 1 && $urandom_range(0, 99) < data_pct)
                send_data($urandom_range(1, 3));
        end
    endtask

    // Hold the sender off until every pending result is back
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Result sink, checker and watchdog
    initial begin
        out_if.ready <= 1'b0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.byte_out, out_if.not_keyed);
            if (!i_rst_n || (out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
        $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus
    initial begin
        int phase;
        int next_phase_at;
        int roll;
        int len;
        i_rst_n        <= 1'b0;
        in_if.valid    <= 1'b0;
        in_if.opcode   <= rc4_pkg::OP_KEY;
        in_if.byte_in  <= '0;
        in_if.key_last <= 1'b0;
        set_phase(0);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Data ahead of any key
        send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'hFF, 1'b1);
        // Three-byte key, then data including both extremes
        send_item(rc4_pkg::OP_KEY, 8'h4B, 1'b0);
        send_item(rc4_pkg::OP_KEY, 8'h65, 1'b0);
        send_item(rc4_pkg::OP_KEY, 8'h79, 1'b1);
        send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'hA5, 1'b1);
        // One-byte keys of all ones and all zeros
        send_item(rc4_pkg::OP_KEY, 8'hFF, 1'b1);
        send_item(rc4_pkg::OP_DATA, 8'h5A, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'hFF, 1'b0);
        send_item(rc4_pkg::OP_KEY, 8'h00, 1'b1);
        send_item(rc4_pkg::OP_DATA, 8'h00, 1'b0);
        // Partial key load: old permutation keeps serving data
        send_item(rc4_pkg::OP_KEY, 8'h12, 1'b0);
        send_item(rc4_pkg::OP_KEY, 8'h34, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'h80, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'h01, 1'b1);
        send_item(rc4_pkg::OP_KEY, 8'h56, 1'b1);
        send_item(rc4_pkg::OP_DATA, 8'h7F, 1'b0);
        send_item(rc4_pkg::OP_DATA, 8'hFE, 1'b1);

        // Full key store, then an overlong key whose extra bytes are dropped
        send_key(rc4_pkg::MAX_KEY_BYTES, 0);
        send_data(8);
        send_key(rc4_pkg::MAX_KEY_BYTES + 3, 0);
        send_data(8);

        // Random mix of keys and data bursts, idling changes per phase
        phase         = 0;
        next_phase_at = items_sent + PHASE_ITEMS;
        while (items_sent < N_ITEMS) begin
            if (items_sent >= next_phase_at) begin
                drain();
                phase++;
                set_phase(phase);
                next_phase_at = items_sent + PHASE_ITEMS;
            end
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64)
                                                   : $urandom_range(1, 16);
                send_key(len, ($urandom_range(0, 3) == 0) ? 20 : 0);
            end else begin
                send_data($urandom_range(1, 24));
            end
        end

        // Let everything come back, then allow for a trailing key schedule
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.flush_leftovers();

        $display("Covered %0d items: %0d key schedules, %0d key bytes stored, %0d dropped",
                 items_sent, sb.schedules, sb.key_bytes_taken, sb.key_bytes_dropped);
        $display("Checked %0d results, %0d of them before any key; %0d mismatches",
                 sb.results_seen, sb.unkeyed_results, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/rc4_pkg.sv
sv/rc4_if.sv
sv/rc4_ram.sv
sv/rc4_stream_cipher.sv
dv/tb_top.sv
